/* hw/rtl/k_queues_shared_buffer_core_defines.svh */
// Assertion macros shared by the RTL. Each expects clk and rst in scope.
`ifndef K_QUEUES_SHARED_BUFFER_CORE_DEFINES_SVH
`define K_QUEUES_SHARED_BUFFER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled during reset.
`define AST_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define AST_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define AST_IMPL(label, ante, cons)
`define AST_NEXT(label, ante, cons)

`endif

`endif

/* hw/rtl/kqsb_pkg.sv */
package kqsb_pkg;

  localparam int SLOTS  = 16;
  localparam int QUEUES = 4;

  // Pointer width covers every slot plus the null code (SLOTS).
  localparam int PTR_W  = $clog2(SLOTS + 1);
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int QIDX_W = (QUEUES > 1) ? $clog2(QUEUES) : 1;

  localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(SLOTS);

  localparam logic KIND_ENQ = 1'b0;
  localparam logic KIND_DEQ = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;

  typedef logic [PTR_W-1:0] ptr_t;

  typedef struct packed {
    logic               kind;
    logic [1:0]         queue_id;
    logic signed [31:0] value_in;
  } cmd_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] value_out;
  } res_t;

  function automatic logic is_slot(ptr_t p);
    return int'(p) < SLOTS;
  endfunction

  // Fold a queue number into range by repeated subtraction (at most three steps).
  function automatic logic [QIDX_W-1:0] queue_index(logic [1:0] id);
    logic [2:0] r;
    r = {1'b0, id};
    for (int i = 0; i < 3; i++) begin
      if (int'(r) >= QUEUES) begin
        r = r - 3'(QUEUES);
      end
    end
    return QIDX_W'(r);
  endfunction

endpackage

/* hw/rtl/k_queues_shared_buffer_core.sv */
// K FIFO queues sharing one slot store, each queue a linked list of slots,
// unused slots kept on a free list that works as a stack.
//
// Command channel: a beat is taken at a rising edge with start high and busy
// low. cmd.kind selects enqueue or dequeue, cmd.queue_id the queue and
// cmd.value_in the value to append. busy is low except while rst is high,
// so a new command may be issued every cycle.
//
// Result channel: done is high for exactly one cycle per command and
// result.status / result.value_out are valid in that cycle. Results come in
// command order, passing the command register and then the pointer update
// into the result register. The receiver cannot stall; each result must be
// taken in its cycle.
//
// Throughput: one command per cycle outside reset, set by the single pass through the
// head/tail/link registers, which are updated before the next command reads.
//
// Reset (synchronous): all queues empty, free list chains slot 0 to the last
// slot, any command in flight is dropped.
module k_queues_shared_buffer_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  kqsb_pkg::cmd_t cmd,
  output logic          done,
  output kqsb_pkg::res_t result
);
  import kqsb_pkg::*;
  `include "k_queues_shared_buffer_core_defines.svh"

  // Command register
  logic              v1;
  logic              kind1;
  logic [QIDX_W-1:0] q1;
  logic signed [31:0] val1;

  // Queue state
  ptr_t              head [QUEUES];
  ptr_t              tail [QUEUES];
  ptr_t              link [SLOTS];
  logic signed [31:0] store [SLOTS];
  ptr_t              free_head;

  logic accept;
  logic enq_ok, deq_ok, enq_ovf, deq_unf;
  ptr_t head_q, tail_q;
  logic [SLOT_W-1:0] free_idx, head_idx, tail_idx;

  assign busy   = rst;
  assign accept = start && !busy;

  assign head_q   = head[q1];
  assign tail_q   = tail[q1];
  assign free_idx = free_head[SLOT_W-1:0];
  assign head_idx = head_q[SLOT_W-1:0];
  assign tail_idx = tail_q[SLOT_W-1:0];

  assign enq_ok  = v1 && (kind1 == KIND_ENQ) && is_slot(free_head);
  assign enq_ovf = v1 && (kind1 == KIND_ENQ) && !is_slot(free_head);
  assign deq_ok  = v1 && (kind1 == KIND_DEQ) && is_slot(head_q);
  assign deq_unf = v1 && (kind1 == KIND_DEQ) && !is_slot(head_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= accept;
    end
    kind1 <= cmd.kind;
    q1    <= queue_index(cmd.queue_id);
    val1  <= cmd.value_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < QUEUES; i++) begin
        head[i] <= NULL_PTR;
        tail[i] <= NULL_PTR;
      end
      for (int i = 0; i < SLOTS - 1; i++) begin
        link[i] <= PTR_W'(i + 1);
      end
      link[SLOTS-1] <= NULL_PTR;
      free_head     <= '0;
    end else if (enq_ok) begin
      // pop the free list, append the slot at the queue tail
      free_head <= link[free_idx];
      if (!is_slot(head_q)) begin
        head[q1] <= free_head;
      end else if (is_slot(tail_q)) begin
        link[tail_idx] <= free_head;
      end
      link[free_idx] <= NULL_PTR;
      tail[q1]       <= free_head;
    end else if (deq_ok) begin
      // unlink the head, push its slot back on the free list
      head[q1]       <= link[head_idx];
      link[head_idx] <= free_head;
      free_head      <= head_q;
    end
  end

  always_ff @(posedge clk) begin
    if (enq_ok) begin
      store[free_idx] <= val1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v1;
    end
    if (deq_ok) begin
      result.status    <= ST_OK;
      result.value_out <= store[head_idx];
    end else if (deq_unf) begin
      result.status    <= ST_UNDERFLOW;
      result.value_out <= '1;
    end else if (enq_ovf) begin
      result.status    <= ST_OVERFLOW;
      result.value_out <= '0;
    end else begin
      result.status    <= ST_OK;
      result.value_out <= '0;
    end
  end

  `AST_NEXT(a_done_follows_cmd, v1, done)
  `AST_NEXT(a_no_spurious_done, !v1, !done)
  `AST_NEXT(a_ovf_reported, enq_ovf, result.status == ST_OVERFLOW)
  `AST_NEXT(a_enq_sets_tail, enq_ok, tail[$past(q1)] == $past(free_head))
  `AST_NEXT(a_deq_frees_head, deq_ok, free_head == $past(head_q))

endmodule
